// ----- rtl/core/rotate_point_about_pivot_macros.svh -----
// ----------------------------------------------------------------------------
// rotate_point_about_pivot assertion macros
// clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_PIVOT_MACROS_SVH
`define ROTATE_POINT_ABOUT_PIVOT_MACROS_SVH

// same-cycle implication
`define RPP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpp check failed");

// next-cycle implication
`define RPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpp check failed");

`endif

// ----- rtl/core/rpp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpp_pkg
// shared widths, constants, types and the arctangent table of the point
// rotation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpp_pkg;

  // coordinate and angle formats
  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 32;
  localparam int CORDIC_STEPS = 24;

  // datapath widths
  localparam int DP_WIDTH   = 64;
  localparam int GUARD_BITS = 60 - COORD_WIDTH;
  localparam int OFS_WIDTH  = COORD_WIDTH + 1;
  localparam int Z_WIDTH    = 34;
  localparam int RND_WIDTH  = DP_WIDTH - GUARD_BITS;
  localparam int SUM_WIDTH  = RND_WIDTH + 1;

  // stream widths
  localparam int IN_PAYLOAD_WIDTH  = 4 * COORD_WIDTH + ANGLE_WIDTH;
  localparam int IN_TDATA_WIDTH    = ((IN_PAYLOAD_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAYLOAD_WIDTH = 2 * COORD_WIDTH;
  localparam int OUT_TDATA_WIDTH   = ((OUT_PAYLOAD_WIDTH + 7) / 8) * 8;

  // angle reduction: integer degrees split as 8 * w + low3, w reduced mod 45
  localparam logic [10:0] RECIP_45    = 11'd1456;   // floor(2^16 / 45)
  localparam logic [12:0] MUL_45      = 13'd45;
  localparam logic [6:0]  MOD_45      = 7'd45;
  localparam logic [9:0]  MOD_OFFSET  = 10'd352;    // -(32768 mod 360) mod 360
  localparam logic [9:0]  DEG_TURN    = 10'd360;
  localparam logic [24:0] DEG_HALF    = 25'd11796480;
  localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
  localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;

  // degrees to radians, pi/180 in Q0.32
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam int          RAD_SHIFT   = 18;
  localparam int          RAD_PROD_W  = 23 + 27;

  // inverse cordic gain in Q30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam int          GAIN_SHIFT   = 30;
  localparam int          MUL_SPLIT    = 32;
  localparam int          HI_WIDTH     = DP_WIDTH - 1 - MUL_SPLIT;

  // point of coordinate width
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } rpp_pt_t;

  // scaled offset vector in the cordic datapath
  typedef struct packed {
    logic signed [DP_WIDTH-1:0] y;
    logic signed [DP_WIDTH-1:0] x;
  } rpp_vec_t;

  // gain corrected, scaled back offset
  typedef struct packed {
    logic signed [RND_WIDTH-1:0] y;
    logic signed [RND_WIDTH-1:0] x;
  } rpp_rnd_t;

  // atan(2^-i) in Q30 radians, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h3243F6A8;
      5'd1:  val = 32'h1DAC6705;
      5'd2:  val = 32'h0FADBAFC;
      5'd3:  val = 32'h07F56EA6;
      5'd4:  val = 32'h03FEAB76;
      5'd5:  val = 32'h01FFD55B;
      5'd6:  val = 32'h00FFFAAA;
      5'd7:  val = 32'h007FFF55;
      5'd8:  val = 32'h003FFFEA;
      5'd9:  val = 32'h001FFFFD;
      5'd10: val = 32'h000FFFFF;
      5'd11: val = 32'h0007FFFF;
      5'd12: val = 32'h0003FFFF;
      5'd13: val = 32'h0001FFFF;
      5'd14: val = 32'h0000FFFF;
      5'd15: val = 32'h00007FFF;
      5'd16: val = 32'h00003FFF;
      5'd17: val = 32'h00001FFF;
      5'd18: val = 32'h00000FFF;
      5'd19: val = 32'h000007FF;
      5'd20: val = 32'h000003FF;
      5'd21: val = 32'h000001FF;
      5'd22: val = 32'h000000FF;
      5'd23: val = 32'h0000007F;
      5'd24: val = 32'h0000003F;
      5'd25: val = 32'h0000001F;
      5'd26: val = 32'h0000000F;
      5'd27: val = 32'h00000008;
      5'd28: val = 32'h00000004;
      5'd29: val = 32'h00000002;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/core/rpp_angle_reduce.sv -----
// ----------------------------------------------------------------------------
// rpp_angle_reduce
// six-stage front end: offsets from the pivot, angle mod 360, fold into
// (-180, 180], quarter-turn swap, conversion to Q30 radians
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpp_angle_reduce (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  rpp_pkg::rpp_pt_t                   in_pt,
  input  logic [rpp_pkg::ANGLE_WIDTH-1:0]    in_angle,
  input  rpp_pkg::rpp_pt_t                   in_pivot,
  output logic                               out_valid,
  output rpp_pkg::rpp_vec_t                  out_vec,
  output logic signed [rpp_pkg::Z_WIDTH-1:0] out_z,
  output rpp_pkg::rpp_pt_t                   out_pivot
);

  localparam int OW = rpp_pkg::OFS_WIDTH;

  // valid bits per stage
  logic [5:0] v_r;

  // stage 1 registers
  logic signed [OW-1:0] dx1_r, dy1_r;
  logic [12:0]          w1_r;
  logic [2:0]           lo1_r;
  logic [15:0]          frac1_r;
  logic [7:0]           qe1_r;
  rpp_pkg::rpp_pt_t     pv1_r;

  // stage 2 registers
  logic signed [OW-1:0] dx2_r, dy2_r;
  logic [5:0]           r2_r;
  logic [2:0]           lo2_r;
  logic [15:0]          frac2_r;
  rpp_pkg::rpp_pt_t     pv2_r;

  // stage 3 registers
  logic signed [OW-1:0] dx3_r, dy3_r;
  logic signed [25:0]   ang3_r;
  rpp_pkg::rpp_pt_t     pv3_r;

  // stage 4 registers
  logic signed [OW-1:0] dx4_r, dy4_r;
  logic [22:0]          mag4_r;
  logic                 neg4_r;
  rpp_pkg::rpp_pt_t     pv4_r;

  // stage 5 registers
  logic signed [OW-1:0]              dx5_r, dy5_r;
  logic [rpp_pkg::RAD_PROD_W-1:0]    prod5_r;
  logic                              neg5_r;
  rpp_pkg::rpp_pt_t                  pv5_r;

  // stage 6 registers
  rpp_pkg::rpp_vec_t                 vec6_r;
  logic signed [rpp_pkg::Z_WIDTH-1:0] z6_r;
  rpp_pkg::rpp_pt_t                  pv6_r;

  // stage 1: offsets, integer degrees biased to unsigned, quotient estimate by 45
  logic [15:0] ideg_u;
  logic [23:0] qe_prod;
  assign ideg_u  = {~in_angle[31], in_angle[30:16]};
  assign qe_prod = 24'(ideg_u[15:3]) * 24'(rpp_pkg::RECIP_45);

  // stage 2: remainder mod 45 with one correction
  logic [12:0] q45;
  logic [6:0]  rem7;
  logic [5:0]  rem45;
  assign q45   = 13'(qe1_r) * rpp_pkg::MUL_45;
  assign rem7  = 7'(w1_r - q45);
  assign rem45 = (rem7 >= rpp_pkg::MOD_45) ? 6'(rem7 - rpp_pkg::MOD_45) : 6'(rem7);

  // stage 3: degrees mod 360, fold to (-180, 180]
  logic [9:0]         msum;
  logic [8:0]         mdeg;
  logic [24:0]        amod;
  logic signed [25:0] afold;
  assign msum  = 10'({r2_r, lo2_r}) + rpp_pkg::MOD_OFFSET;
  assign mdeg  = (msum >= rpp_pkg::DEG_TURN) ? 9'(msum - rpp_pkg::DEG_TURN) : 9'(msum);
  assign amod  = {mdeg, frac2_r};
  assign afold = (amod > rpp_pkg::DEG_HALF) ? $signed({1'b0, amod}) - rpp_pkg::DEG_FULL
                                            : $signed({1'b0, amod});

  // stage 4: exact quarter turn and magnitude of the residual
  logic signed [OW-1:0] dx_q, dy_q;
  logic signed [25:0]   ares;
  logic [25:0]          aabs;
  always_comb begin
    dx_q = dx3_r;
    dy_q = dy3_r;
    ares = ang3_r;
    if (ang3_r >= rpp_pkg::DEG_QUARTER) begin
      dx_q = -dy3_r;
      dy_q = dx3_r;
      ares = ang3_r - rpp_pkg::DEG_QUARTER;
    end else if (ang3_r <= -rpp_pkg::DEG_QUARTER) begin
      dx_q = dy3_r;
      dy_q = -dx3_r;
      ares = ang3_r + rpp_pkg::DEG_QUARTER;
    end
  end
  assign aabs = ares[25] ? 26'(-ares) : 26'(ares);

  // stage 6: round to Q30 radians, restore sign, scale offsets up
  logic [rpp_pkg::RAD_PROD_W-1:0]      zsum;
  logic [31:0]                         zmag;
  logic signed [rpp_pkg::Z_WIDTH-1:0]  zpos;
  assign zsum = prod5_r + (rpp_pkg::RAD_PROD_W'(1) << (rpp_pkg::RAD_SHIFT - 1));
  assign zmag = zsum[rpp_pkg::RAD_SHIFT +: 32];
  assign zpos = $signed({{(rpp_pkg::Z_WIDTH-32){1'b0}}, zmag});

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= $signed({in_pt.x[rpp_pkg::COORD_WIDTH-1], in_pt.x})
               - $signed({in_pivot.x[rpp_pkg::COORD_WIDTH-1], in_pivot.x});
      dy1_r   <= $signed({in_pt.y[rpp_pkg::COORD_WIDTH-1], in_pt.y})
               - $signed({in_pivot.y[rpp_pkg::COORD_WIDTH-1], in_pivot.y});
      w1_r    <= ideg_u[15:3];
      lo1_r   <= ideg_u[2:0];
      frac1_r <= in_angle[15:0];
      qe1_r   <= qe_prod[23:16];
      pv1_r   <= in_pivot;

      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      r2_r    <= rem45;
      lo2_r   <= lo1_r;
      frac2_r <= frac1_r;
      pv2_r   <= pv1_r;

      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      ang3_r  <= afold;
      pv3_r   <= pv2_r;

      dx4_r   <= dx_q;
      dy4_r   <= dy_q;
      mag4_r  <= aabs[22:0];
      neg4_r  <= ares[25];
      pv4_r   <= pv3_r;

      dx5_r   <= dx4_r;
      dy5_r   <= dy4_r;
      prod5_r <= rpp_pkg::RAD_PROD_W'(mag4_r) * rpp_pkg::RAD_PROD_W'(rpp_pkg::DEG2RAD_Q32);
      neg5_r  <= neg4_r;
      pv5_r   <= pv4_r;

      vec6_r.x <= rpp_pkg::DP_WIDTH'(dx5_r) <<< rpp_pkg::GUARD_BITS;
      vec6_r.y <= rpp_pkg::DP_WIDTH'(dy5_r) <<< rpp_pkg::GUARD_BITS;
      z6_r     <= neg5_r ? -zpos : zpos;
      pv6_r    <= pv5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_vec   = vec6_r;
  assign out_z     = z6_r;
  assign out_pivot = pv6_r;

endmodule

// ----- rtl/core/rpp_cordic.sv -----
// ----------------------------------------------------------------------------
// rpp_cordic
// unrolled rotation-mode cordic, one micro-rotation per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpp_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  rpp_pkg::rpp_vec_t                  in_vec,
  input  logic signed [rpp_pkg::Z_WIDTH-1:0] in_z,
  input  rpp_pkg::rpp_pt_t                   in_pivot,
  output logic                               out_valid,
  output rpp_pkg::rpp_vec_t                  out_vec,
  output rpp_pkg::rpp_pt_t                   out_pivot
);

  localparam int N  = rpp_pkg::CORDIC_STEPS;
  localparam int DW = rpp_pkg::DP_WIDTH;
  localparam int ZW = rpp_pkg::Z_WIDTH;

  // stage registers
  logic                 v_r  [N];
  logic signed [DW-1:0] x_r  [N];
  logic signed [DW-1:0] y_r  [N];
  logic signed [ZW-1:0] z_r  [N];
  rpp_pkg::rpp_pt_t     pv_r [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                 vi;
    logic signed [DW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] zi, ai;
    rpp_pkg::rpp_pt_t     pi;

    // stage input
    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_vec.x;
      assign yi = in_vec.y;
      assign zi = in_z;
      assign pi = in_pivot;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign pi = pv_r[i-1];
    end

    assign xs = xi >>> i;
    assign ys = yi >>> i;
    assign ai = $signed({{(ZW-32){1'b0}}, rpp_pkg::atan_q30(5'(i))});

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    // micro-rotation, direction from the sign of the residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ZW-1]) begin
          x_r[i] <= xi - ys;
          y_r[i] <= yi + xs;
          z_r[i] <= zi - ai;
        end else begin
          x_r[i] <= xi + ys;
          y_r[i] <= yi - xs;
          z_r[i] <= zi + ai;
        end
        pv_r[i] <= pi;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_vec.x = x_r[N-1];
  assign out_vec.y = y_r[N-1];
  assign out_pivot = pv_r[N-1];

endmodule

// ----- rtl/core/rpp_gain_scale.sv -----
// ----------------------------------------------------------------------------
// rpp_gain_scale
// five-stage back end: inverse gain multiply split in two partial products,
// rounding half away from zero, then scale back by the guard bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpp_gain_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  rpp_pkg::rpp_vec_t in_vec,
  input  rpp_pkg::rpp_pt_t  in_pivot,
  output logic              out_valid,
  output rpp_pkg::rpp_rnd_t out_rnd,
  output rpp_pkg::rpp_pt_t  out_pivot
);

  localparam int DW = rpp_pkg::DP_WIDTH;
  localparam int HW = rpp_pkg::HI_WIDTH;
  localparam int SP = rpp_pkg::MUL_SPLIT;
  localparam int GS = rpp_pkg::GAIN_SHIFT;
  localparam int GB = rpp_pkg::GUARD_BITS;
  localparam int RW = rpp_pkg::RND_WIDTH;
  localparam int LW = SP + 30;

  // valid and pivot per stage
  logic [4:0]       v_r;
  rpp_pkg::rpp_pt_t pv_r [5];

  // lane inputs and outputs
  logic signed [DW-1:0] lane_in  [2];
  logic signed [RW-1:0] lane_out [2];

  assign lane_in[0] = in_vec.x;
  assign lane_in[1] = in_vec.y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic                 neg1_r, neg2_r, neg3_r;
    logic [DW-2:0]        mag1_r;
    logic [HW+29:0]       hi2_r;
    logic [LW-1:0]        lo2_r;
    logic [DW-1:0]        r3_r;
    logic signed [DW-1:0] s4_r;
    logic signed [RW-1:0] q5_r;
    logic [DW-1:0]        absv;
    logic [LW:0]          lo_rnd;
    logic signed [DW-1:0] rnd_sum;

    // stage 1: sign and magnitude
    assign absv = lane_in[l][DW-1] ? DW'(-lane_in[l]) : DW'(lane_in[l]);

    // stage 3: recombine partial products with rounding of the low part
    assign lo_rnd = {1'b0, lo2_r} + ((LW+1)'(1) << (GS - 1));

    // stage 5: add half an lsb of the output and drop the guard bits
    assign rnd_sum = s4_r + (DW'(1) << (GB - 1));

    always_ff @(posedge clk) begin
      if (en) begin
        neg1_r <= lane_in[l][DW-1];
        mag1_r <= absv[DW-2:0];

        neg2_r <= neg1_r;
        hi2_r  <= (HW+30)'(mag1_r[DW-2:SP]) * (HW+30)'(rpp_pkg::INV_GAIN_Q30);
        lo2_r  <= LW'(mag1_r[SP-1:0]) * LW'(rpp_pkg::INV_GAIN_Q30);

        neg3_r <= neg2_r;
        r3_r   <= DW'({hi2_r, 2'b00}) + DW'(lo_rnd[LW:GS]);

        s4_r   <= neg3_r ? -$signed(r3_r) : $signed(r3_r);

        q5_r   <= rnd_sum[DW-1:GB];
      end
    end

    assign lane_out[l] = q5_r;
  end

  // valid and pivot alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv_r[0] <= in_pivot;
      pv_r[1] <= pv_r[0];
      pv_r[2] <= pv_r[1];
      pv_r[3] <= pv_r[2];
      pv_r[4] <= pv_r[3];
    end
  end

  assign out_valid = v_r[4];
  assign out_rnd.x = lane_out[0];
  assign out_rnd.y = lane_out[1];
  assign out_pivot = pv_r[4];

endmodule

// ----- rtl/core/rotate_point_about_pivot.sv -----
// ----------------------------------------------------------------------------
// rotate_point_about_pivot
// Rotates a Q16.16 point counter-clockwise about a Q16.16 pivot by an angle
// in Q16.16 degrees and gives the result saturated to the coordinate range.
// The block takes one transaction per clock while in_tready is high and
// returns one result per transaction, in order. The path from input
// acceptance to out_tvalid runs through six front-end stages for angle
// reduction and radian conversion, one stage per cordic micro-rotation, five
// stages for the gain multiply and rounding, and the output register. A
// two-entry output buffer lets the pipeline keep accepting while a result
// waits; in_tready drops only when that buffer is full, and stays low during
// reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotate_point_about_pivot_macros.svh"

module rotate_point_about_pivot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // vx, vy, angle_deg, pivot_x, pivot_y from the lowest bit up
  input  logic [rpp_pkg::IN_TDATA_WIDTH-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // rx, ry from the lowest bit up
  output logic [rpp_pkg::OUT_TDATA_WIDTH-1:0] out_tdata
);

  localparam int CW = rpp_pkg::COORD_WIDTH;
  localparam int SW = rpp_pkg::SUM_WIDTH;
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

  // pipeline enable, held while the output buffer is full
  logic en;

  // unpack the input transaction
  rpp_pkg::rpp_pt_t                in_pt, in_pivot;
  logic [rpp_pkg::ANGLE_WIDTH-1:0] in_angle;
  assign in_pt.x    = in_tdata[0 +: CW];
  assign in_pt.y    = in_tdata[CW +: CW];
  assign in_angle   = in_tdata[2*CW +: rpp_pkg::ANGLE_WIDTH];
  assign in_pivot.x = in_tdata[2*CW + rpp_pkg::ANGLE_WIDTH +: CW];
  assign in_pivot.y = in_tdata[3*CW + rpp_pkg::ANGLE_WIDTH +: CW];

  // front end
  logic                               a_valid;
  rpp_pkg::rpp_vec_t                  a_vec;
  logic signed [rpp_pkg::Z_WIDTH-1:0] a_z;
  rpp_pkg::rpp_pt_t                   a_pivot;

  rpp_angle_reduce u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_pt     (in_pt),
    .in_angle  (in_angle),
    .in_pivot  (in_pivot),
    .out_valid (a_valid),
    .out_vec   (a_vec),
    .out_z     (a_z),
    .out_pivot (a_pivot)
  );

  // cordic rotation
  logic              c_valid;
  rpp_pkg::rpp_vec_t c_vec;
  rpp_pkg::rpp_pt_t  c_pivot;

  rpp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid),
    .in_vec    (a_vec),
    .in_z      (a_z),
    .in_pivot  (a_pivot),
    .out_valid (c_valid),
    .out_vec   (c_vec),
    .out_pivot (c_pivot)
  );

  // gain and scale back
  logic              g_valid;
  rpp_pkg::rpp_rnd_t g_rnd;
  rpp_pkg::rpp_pt_t  g_pivot;

  rpp_gain_scale u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .in_vec    (c_vec),
    .in_pivot  (c_pivot),
    .out_valid (g_valid),
    .out_rnd   (g_rnd),
    .out_pivot (g_pivot)
  );

  // pivot add and saturation
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[CW-1:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[CW-1:0];
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  logic signed [SW-1:0] sum_x, sum_y;
  rpp_pkg::rpp_pt_t     res_pt;
  logic                 push;
  assign sum_x    = SW'($signed(g_rnd.x)) + SW'($signed(g_pivot.x));
  assign sum_y    = SW'($signed(g_rnd.y)) + SW'($signed(g_pivot.y));
  assign res_pt.x = sat_coord(sum_x);
  assign res_pt.y = sat_coord(sum_y);
  assign push     = en && g_valid;

  // output register with skid entry
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  rpp_pkg::rpp_pt_t out_pt_r, out_pt_nxt;
  rpp_pkg::rpp_pt_t skid_pt_r, skid_pt_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pt_nxt     = out_pt_r;
    skid_valid_nxt = skid_valid_r;
    skid_pt_nxt    = skid_pt_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_pt_nxt     = skid_pt_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_pt_nxt    = res_pt;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_pt_nxt    = res_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pt_r  <= out_pt_nxt;
    skid_pt_r <= skid_pt_nxt;
  end

  assign en         = !skid_valid_r;
  assign in_tready  = en && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = rpp_pkg::OUT_TDATA_WIDTH'({out_pt_r.y, out_pt_r.x});

  // checks on the output buffer and the stall
  `RPP_ASSERT_IMPL(a_skid_needs_out, skid_valid_r, out_valid_r)
  `RPP_ASSERT_NEXT(a_overflow_to_skid, out_valid_r && !out_tready && push, skid_valid_r)
  `RPP_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_tready, !skid_valid_r && out_valid_r)
  `RPP_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(g_valid) && $stable(g_rnd))

endmodule

// ----- test/rotate_point_about_pivot_tb.sv -----
// ----------------------------------------------------------------------------
// rotate_point_about_pivot_tb
// Streams points, pivots and angles into the rotation pipeline and checks each
// rotated point against a cycle-free bit-exact model of the angle reduction,
// the cordic micro-rotations, the gain correction and the output saturation.
// Both stream sides idle at random, the receiver also holds off long enough
// to fill the pipeline, and the sender pauses once for a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotate_point_about_pivot_tb;

  // q16.16 constants
  localparam int ONE_Q16     = 32'h0001_0000;
  localparam int DEG90_Q16   = 5898240;
  localparam int DEG180_Q16  = 11796480;
  localparam int COORD_MAX   = 32'h7FFF_FFFF;
  localparam int COORD_MIN   = 32'h8000_0000;

  // model constants
  localparam longint          TURN_Q16    = 23592960;
  localparam longint          HALF_Q16    = 11796480;
  localparam longint          QUARTER_Q16 = 5898240;
  localparam longint unsigned PI_OVER_180 = 64'd74961321;
  localparam longint unsigned CORDIC_GAIN = 64'd652032874;
  localparam int              SCALE_SHIFT = 60 - rpp_pkg::COORD_WIDTH;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic signed [rpp_pkg::COORD_WIDTH-1:0] vx;
    logic signed [rpp_pkg::COORD_WIDTH-1:0] vy;
    logic signed [rpp_pkg::ANGLE_WIDTH-1:0] angle;
    logic signed [rpp_pkg::COORD_WIDTH-1:0] px;
    logic signed [rpp_pkg::COORD_WIDTH-1:0] py;
  } point_req_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  // vx, vy, angle_deg, pivot_x, pivot_y from the lowest bit up
  logic [rpp_pkg::IN_TDATA_WIDTH-1:0]  in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  // rx, ry from the lowest bit up
  logic [rpp_pkg::OUT_TDATA_WIDTH-1:0] out_tdata;

  rpp_pkg::rpp_pt_t expected_points[$];
  int      points_sent   = 0;
  int      points_checked = 0;
  int      error_count   = 0;
  int      cycle_count   = 0;
  bit      idle_enable   = 1'b1;
  int      hold_request  = 0;

  // arctangent steps in q30 radians, truncated
  longint atan_step [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  rotate_point_about_pivot dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_points.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // round(v * inverse gain / 2^30), half away from zero
  function automatic longint gain_correct(input longint v);
    logic [63:0] mag, hi, lo, r;
    mag = (v < 0) ? -v : v;
    hi  = (mag >> 32) * CORDIC_GAIN;
    lo  = (mag & 64'hFFFF_FFFF) * CORDIC_GAIN;
    r   = (hi << 2) + ((lo + (64'd1 << 29)) >> 30);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [rpp_pkg::COORD_WIDTH-1:0] clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (rpp_pkg::COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[rpp_pkg::COORD_WIDTH-1:0];
  endfunction

  // rotated point for one request
  function automatic rpp_pkg::rpp_pt_t rotate_about_pivot(input point_req_t p);
    longint dx, dy, t, a, x, y, z, xs, ys;
    longint unsigned mag;
    rpp_pkg::rpp_pt_t r;
    dx = longint'(p.vx) - longint'(p.px);
    dy = longint'(p.vy) - longint'(p.py);
    // reduce into (-180, 180], then strip a quarter turn exactly
    a = longint'(p.angle) % TURN_Q16;
    if (a < 0) a += TURN_Q16;
    if (a > HALF_Q16) a -= TURN_Q16;
    if (a >= QUARTER_Q16) begin
      t = dx; dx = -dy; dy = t;
      a -= QUARTER_Q16;
    end else if (a <= -QUARTER_Q16) begin
      t = dx; dx = dy; dy = -t;
      a += QUARTER_Q16;
    end
    // residual to q30 radians
    mag = (a < 0) ? -a : a;
    z = longint'((mag * PI_OVER_180 + (64'd1 << 17)) >> 18);
    if (a < 0) z = -z;
    // micro-rotations
    x = dx <<< SCALE_SHIFT;
    y = dy <<< SCALE_SHIFT;
    for (int i = 0; i < rpp_pkg::CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step[i];
      end else begin
        x += ys; y -= xs; z += atan_step[i];
      end
    end
    // gain, scale back with round half up, add pivot
    x = (gain_correct(x) + (longint'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    y = (gain_correct(y) + (longint'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    r.x = clamp_coord(x + longint'(p.px));
    r.y = clamp_coord(y + longint'(p.py));
    return r;
  endfunction

  // mixed random request, weighted toward the interesting corners
  function automatic point_req_t random_point();
    point_req_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.vx = $urandom; p.vy = $urandom; p.angle = $urandom;
    p.px = $urandom; p.py = $urandom;
    case (kind)
      4, 5: begin
        // small offsets, angle within two turns
        p.vx = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        p.vy = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        p.px = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        p.py = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        p.angle = int'($urandom_range(0, 94371840)) - 47185920;
      end
      6: begin
        // whole quarter turns, exact or one lsb off
        p.vx = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        p.vy = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        p.angle = (int'($urandom_range(0, 16)) - 8) * DEG90_Q16
                  + int'($urandom_range(0, 2)) - 1;
      end
      7: begin
        // offsets near full scale
        p.px = p.vx ^ 32'h8000_0000;
        p.py = p.vy ^ {1'b1, 31'($urandom)};
      end
      8: begin
        // point and pivot at opposite extremes, drives saturation
        p.vx = $urandom_range(0, 1) ? (COORD_MAX - $urandom_range(0, 32'hFFFF))
                                    : (COORD_MIN + $urandom_range(0, 32'hFFFF));
        p.vy = $urandom_range(0, 1) ? (COORD_MAX - $urandom_range(0, 32'hFFFF))
                                    : (COORD_MIN + $urandom_range(0, 32'hFFFF));
        p.px = ~p.vx;
        p.py = ~p.vy;
      end
      9: begin
        // zero offset
        p.px = p.vx;
        p.py = p.vy;
      end
      default: ;
    endcase
    return p;
  endfunction

  // one transaction on the input side
  task automatic send_point(input point_req_t p);
    int gap;
    gap = idle_enable ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {p.py, p.px, p.angle, p.vy, p.vx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_points.push_back(rotate_about_pivot(p));
    points_sent++;
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // receiver: per-result stall, plus long hold-off on request
  initial begin : receiver
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (out_tvalid && out_tready)
        stall = idle_enable ? $urandom_range(0, 4) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expected point
  always @(posedge clk) begin
    rpp_pkg::rpp_pt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[rpp_pkg::OUT_PAYLOAD_WIDTH-1:0];
      if (expected_points.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result rx=%0d ry=%0d", got.x, got.y);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (got.x !== want.x) begin
          if (error_count < 10)
            $display("result %0d rx: expected %0d, got %0d", points_checked - 1,
                     want.x, got.x);
          error_count++;
        end
        if (got.y !== want.y) begin
          if (error_count < 10)
            $display("result %0d ry: expected %0d, got %0d", points_checked - 1,
                     want.y, got.y);
          error_count++;
        end
      end
    end
  end

  // extremes, quarter turns, rounding and saturation corners
  task automatic test_directed();
    point_req_t cases[$];
    cases.push_back('{0, 0, 0, 0, 0});
    cases.push_back('{ONE_Q16, 0, DEG90_Q16, 0, 0});
    cases.push_back('{ONE_Q16, 0, -DEG90_Q16, 0, 0});
    cases.push_back('{ONE_Q16, 2 * ONE_Q16, DEG180_Q16, 0, 0});
    cases.push_back('{ONE_Q16, 2 * ONE_Q16, -DEG180_Q16, 0, 0});
    cases.push_back('{ONE_Q16, 0, 3 * DEG90_Q16, 0, 0});
    cases.push_back('{ONE_Q16, ONE_Q16, 4 * DEG90_Q16, 0, 0});
    cases.push_back('{3 * ONE_Q16, -ONE_Q16, 45 * ONE_Q16, ONE_Q16, ONE_Q16});
    cases.push_back('{ONE_Q16, 0, DEG90_Q16 - 1, 0, 0});
    cases.push_back('{ONE_Q16, 0, -DEG90_Q16 + 1, 0, 0});
    cases.push_back('{ONE_Q16, 0, 1, 0, 0});
    cases.push_back('{ONE_Q16, 0, -1, 0, 0});
    cases.push_back('{ONE_Q16, ONE_Q16, COORD_MAX, 0, 0});
    cases.push_back('{ONE_Q16, ONE_Q16, COORD_MIN, 0, 0});
    cases.push_back('{COORD_MAX, 0, 0, COORD_MIN, 0});
    cases.push_back('{COORD_MIN, COORD_MAX, DEG180_Q16, COORD_MAX, COORD_MIN});
    cases.push_back('{COORD_MAX, COORD_MAX, 45 * ONE_Q16, COORD_MIN, COORD_MIN});
    cases.push_back('{COORD_MIN, COORD_MIN, 45 * ONE_Q16, COORD_MAX, COORD_MAX});
    cases.push_back('{COORD_MAX, COORD_MAX, DEG90_Q16, 0, 0});
    cases.push_back('{COORD_MIN, 0, DEG180_Q16, 0, 0});
    cases.push_back('{-1, -1, -1, -1, -1});
    cases.push_back('{12345, -6789, 30 * ONE_Q16 + 1234, -5000, 7777});
    cases.push_back('{7 * ONE_Q16, -3 * ONE_Q16, 123 * ONE_Q16 + 32768,
                      7 * ONE_Q16, -3 * ONE_Q16});
    cases.push_back('{1, 0, 60 * ONE_Q16, 0, 0});
    foreach (cases[i]) send_point(cases[i]);
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_point(random_point());
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int count);
    idle_enable = 1'b0;
    repeat (count) send_point(random_point());
    idle_enable = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, fills the pipeline
  task automatic test_receiver_hold(input int count);
    idle_enable = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (count) send_point(random_point());
    idle_enable = 1'b1;
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause(input int count);
    wait_results_drained();
    repeat (count) send_point(random_point());
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_stream(380);
    test_back_to_back(60);
    test_receiver_hold(80);
    test_drain_pause(10);
    wait_results_drained();
    repeat (rpp_pkg::CORDIC_STEPS + 20) @(posedge clk);
    $display("checked %0d of %0d rotated points: quarter turns, angle extremes,",
             points_checked, points_sent);
    $display("saturation corners and random angles under stalls and a %0d-cycle hold",
             HOLD_CYCLES);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
